>>> design/ffn_pkg.sv
// ----------------------------------------------------------------------------
// ffn_pkg
// Shared types and constants of the flat face normal unit.
// ----------------------------------------------------------------------------
package ffn_pkg;

  // running output index wraps at this bound
  localparam int unsigned MAX_VERTICES = 65536;
  localparam int unsigned VNUM_W       = 16;
  localparam logic [VNUM_W-1:0] VNUM_LAST = VNUM_W'(MAX_VERTICES - 1);

  // serial multiplier widths
  localparam int unsigned MCAND_W = 36;
  localparam int unsigned MPLIER_W = 32;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned LEN_W = 6;

  // multiplier run lengths (bits of the multiplier, sign bit included)
  localparam logic [LEN_W-1:0] LEN_CROSS = LEN_W'(17);
  localparam logic [LEN_W-1:0] LEN_DOT   = LEN_W'(18);
  localparam logic [LEN_W-1:0] LEN_SQ    = LEN_W'(31);

  // sequencer operation codes
  localparam logic [3:0] OP_CX_A  = 4'd0;
  localparam logic [3:0] OP_CX_B  = 4'd1;
  localparam logic [3:0] OP_CY_A  = 4'd2;
  localparam logic [3:0] OP_CY_B  = 4'd3;
  localparam logic [3:0] OP_CZ_A  = 4'd4;
  localparam logic [3:0] OP_CZ_B  = 4'd5;
  localparam logic [3:0] OP_DOT_X = 4'd6;
  localparam logic [3:0] OP_DOT_Y = 4'd7;
  localparam logic [3:0] OP_DOT_Z = 4'd8;
  localparam logic [3:0] OP_SQ_X  = 4'd9;
  localparam logic [3:0] OP_SQ_Y  = 4'd10;
  localparam logic [3:0] OP_SQ_Z  = 4'd11;

  // last step of the square root and divider, last component and last corner
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [3:0] DIV_LAST  = 4'd15;
  localparam logic [1:0] COMP_LAST = 2'd2;
  localparam logic [1:0] CORNER_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ISSUE,
    ST_MUL_WAIT,
    ST_SCALE,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } ffn_state_e;

  typedef struct packed {
    logic signed [MCAND_W-1:0]  mcand;
    logic signed [MPLIER_W-1:0] mplier;
    logic [LEN_W-1:0]           len;
    logic                       neg;
    logic                       clr;
  } mac_op_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] acc;
  } mac_res_t;

endpackage

>>> design/ffn_mac.sv
// ----------------------------------------------------------------------------
// ffn_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ffn_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ffn_pkg::mac_op_t  op_i,
  output ffn_pkg::mac_res_t res_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [ffn_pkg::LEN_W-1:0]           cnt_q;
  logic [ffn_pkg::LEN_W-1:0]           len_q;
  logic                                neg_q;
  logic [ffn_pkg::ACC_W-1:0]           mcand_q;
  logic [ffn_pkg::MPLIER_W-1:0]        mplier_q;
  logic [ffn_pkg::ACC_W-1:0]           acc_q;
  logic [ffn_pkg::ACC_W-1:0]           acc_d;
  logic [ffn_pkg::ACC_W-1:0]           term;
  logic                                last;
  logic                                sub;

  // sign bit of the multiplier weighs negative
  always_comb begin
    last  = (cnt_q == (len_q - ffn_pkg::LEN_W'(1)));
    sub   = neg_q ^ last;
    term  = mplier_q[0] ? mcand_q : '0;
    acc_d = sub ? (acc_q - term) : (acc_q + term);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ffn_pkg::LEN_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      len_q    <= op_i.len;
      neg_q    <= op_i.neg;
      mcand_q  <= {{(ffn_pkg::ACC_W - ffn_pkg::MCAND_W){op_i.mcand[ffn_pkg::MCAND_W-1]}},
                   op_i.mcand};
      mplier_q <= op_i.mplier;
      if (op_i.clr) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mcand_q  <= {mcand_q[ffn_pkg::ACC_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[ffn_pkg::MPLIER_W-1:1]};
    end
  end

  assign res_o.done = done_q;
  assign res_o.acc  = acc_q;

endmodule

>>> design/flat_face_normal_unit.sv
// ----------------------------------------------------------------------------
// flat_face_normal_unit
// Flat shading of a triangle-list vertex stream with a unit face normal.
// ----------------------------------------------------------------------------
// The slave stream takes one vertex per item: position and vertex normal.
// The first two vertices of a face are held and give no output. The third
// starts the face computation: cross product, orientation dot product and
// squared length on one bit-serial multiplier, a one-bit-per-cycle scaling
// shift, a 32-step square root and a restoring divide per normal component.
// Most of a face's time is spent on the serial multiplier; a degenerate
// face skips the square root and the divide.
// The master stream then gives three items, one per vertex, with the flat
// normal, a running vertex number and tlast on the third vertex.
// The three items wait in an output buffer: the next face's vertices are
// accepted meanwhile, and a new face result waits only if the buffer still
// holds items. A stalled receiver holds data steady.
// Reset clears the corner count, the vertex number and all valid flags.
// ----------------------------------------------------------------------------
module flat_face_normal_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // pos_x, pos_y, pos_z, norm_in_x, norm_in_y, norm_in_z
  input  logic [95:0]   s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, face_norm_x, face_norm_y, face_norm_z,
  // vertex_number
  output logic [111:0]  m_axis_tdata,
  output logic          m_axis_tlast,
  // degenerate
  output logic          m_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready
);

  ffn_pkg::ffn_state_e state_q, state_d;
  ffn_pkg::mac_op_t    mac_op;
  ffn_pkg::mac_res_t   mac_res;
  logic                mac_start;

  logic                s_fire;
  logic                m_fire;
  logic [1:0]          corner_q;

  logic signed [15:0]  in_pos[3];
  logic signed [15:0]  in_nrm[3];
  logic signed [15:0]  hp0_q[3], hp1_q[3], hn0_q[3], hn1_q[3];
  logic signed [15:0]  fpos_q[3][3];
  logic signed [16:0]  e1_q[3], e2_q[3];
  logic signed [17:0]  nsum_q[3];
  logic signed [34:0]  c_q[3];
  logic                dot_neg_q;
  logic [33:0]         mag_q[3];
  logic                degen_q;
  logic [3:0]          op_q;

  logic [63:0]         sq_v_q, sq_res_q, sq_bit_q, sq_t;
  logic [4:0]          sq_iter_q;

  logic [1:0]          comp_q;
  logic [3:0]          dcnt_q;
  logic [45:0]         rem_q, dvs_q;
  logic [14:0]         quo_q, quo_fin;
  logic                div_ge;
  logic signed [15:0]  fn_q[3];
  logic [30:0]         r_w;

  logic                any_high, all_low, all_zero;

  logic signed [15:0]  ebuf_pos_q[3][3];
  logic signed [15:0]  ebuf_nrm_q[3];
  logic                ebuf_deg_q;
  logic [1:0]          eleft_q, eidx_q;
  logic [15:0]         vcnt_q;
  logic                buf_load;

  // field unpacking
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = s_axis_tdata[16*i +: 16];
      in_nrm[i] = s_axis_tdata[48 + 16*i +: 16];
    end
  end

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // scaling tests on the magnitudes
  always_comb begin
    any_high = 1'b0;
    all_low  = 1'b1;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_high = any_high | (|mag_q[i][33:30]);
      all_low  = all_low & ~(|mag_q[i][33:29]);
      all_zero = all_zero & ~(|mag_q[i]);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffn_pkg::ST_IDLE: begin
        if (s_fire && (corner_q == ffn_pkg::CORNER_LAST)) begin
          state_d = ffn_pkg::ST_MUL_ISSUE;
        end
      end
      ffn_pkg::ST_MUL_ISSUE: state_d = ffn_pkg::ST_MUL_WAIT;
      ffn_pkg::ST_MUL_WAIT: begin
        if (mac_res.done) begin
          if (op_q == ffn_pkg::OP_DOT_Z) begin
            state_d = ffn_pkg::ST_SCALE;
          end else if (op_q == ffn_pkg::OP_SQ_Z) begin
            state_d = ffn_pkg::ST_SQRT;
          end else begin
            state_d = ffn_pkg::ST_MUL_ISSUE;
          end
        end
      end
      ffn_pkg::ST_SCALE: begin
        if (all_zero) begin
          state_d = ffn_pkg::ST_DONE;
        end else if (!any_high && !all_low) begin
          state_d = ffn_pkg::ST_MUL_ISSUE;
        end
      end
      ffn_pkg::ST_SQRT: begin
        if (sq_iter_q == ffn_pkg::SQRT_LAST) begin
          state_d = ffn_pkg::ST_DIV;
        end
      end
      ffn_pkg::ST_DIV: begin
        if ((comp_q == ffn_pkg::COMP_LAST) && (dcnt_q == ffn_pkg::DIV_LAST)) begin
          state_d = ffn_pkg::ST_DONE;
        end
      end
      ffn_pkg::ST_DONE: begin
        if (eleft_q == 2'd0) begin
          state_d = ffn_pkg::ST_IDLE;
        end
      end
      default: state_d = ffn_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = (state_q == ffn_pkg::ST_IDLE);
    mac_start     = (state_q == ffn_pkg::ST_MUL_ISSUE);
    buf_load      = (state_q == ffn_pkg::ST_DONE) && (eleft_q == 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // multiplier operand selection
  always_comb begin
    mac_op = '0;
    unique case (op_q)
      ffn_pkg::OP_CX_A: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(e1_q[1]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(e2_q[2]);
        mac_op.clr    = 1'b1;
      end
      ffn_pkg::OP_CX_B: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(e1_q[2]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(e2_q[1]);
        mac_op.neg    = 1'b1;
      end
      ffn_pkg::OP_CY_A: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(e1_q[2]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(e2_q[0]);
        mac_op.clr    = 1'b1;
      end
      ffn_pkg::OP_CY_B: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(e1_q[0]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(e2_q[2]);
        mac_op.neg    = 1'b1;
      end
      ffn_pkg::OP_CZ_A: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(e1_q[0]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(e2_q[1]);
        mac_op.clr    = 1'b1;
      end
      ffn_pkg::OP_CZ_B: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(e1_q[1]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(e2_q[0]);
        mac_op.neg    = 1'b1;
      end
      ffn_pkg::OP_DOT_X: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(c_q[0]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(nsum_q[0]);
        mac_op.clr    = 1'b1;
      end
      ffn_pkg::OP_DOT_Y: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(c_q[1]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(nsum_q[1]);
      end
      ffn_pkg::OP_DOT_Z: begin
        mac_op.mcand  = ffn_pkg::MCAND_W'(c_q[2]);
        mac_op.mplier = ffn_pkg::MPLIER_W'(nsum_q[2]);
      end
      ffn_pkg::OP_SQ_X: begin
        mac_op.mcand  = {2'b00, mag_q[0]};
        mac_op.mplier = {1'b0, mag_q[0][30:0]};
        mac_op.clr    = 1'b1;
      end
      ffn_pkg::OP_SQ_Y: begin
        mac_op.mcand  = {2'b00, mag_q[1]};
        mac_op.mplier = {1'b0, mag_q[1][30:0]};
      end
      ffn_pkg::OP_SQ_Z: begin
        mac_op.mcand  = {2'b00, mag_q[2]};
        mac_op.mplier = {1'b0, mag_q[2][30:0]};
      end
      default: mac_op = '0;
    endcase
    if (op_q == ffn_pkg::OP_DOT_X || op_q == ffn_pkg::OP_DOT_Y ||
        op_q == ffn_pkg::OP_DOT_Z) begin
      mac_op.len = ffn_pkg::LEN_DOT;
    end else if (op_q == ffn_pkg::OP_SQ_X || op_q == ffn_pkg::OP_SQ_Y ||
                 op_q == ffn_pkg::OP_SQ_Z) begin
      mac_op.len = ffn_pkg::LEN_SQ;
    end else begin
      mac_op.len = ffn_pkg::LEN_CROSS;
    end
  end

  ffn_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .op_i    (mac_op),
    .res_o   (mac_res)
  );

  // corner count and op counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      op_q     <= '0;
    end else begin
      if (s_fire) begin
        corner_q <= (corner_q == ffn_pkg::CORNER_LAST) ? 2'd0 : corner_q + 2'd1;
        op_q     <= '0;
      end else if ((state_q == ffn_pkg::ST_MUL_WAIT) && mac_res.done) begin
        op_q <= op_q + 4'd1;
      end
    end
  end

  // square root step
  assign sq_t = sq_res_q + sq_bit_q;
  assign r_w  = sq_res_q[30:0];

  // divider step
  assign div_ge  = (rem_q >= dvs_q);
  assign quo_fin = {quo_q[13:0], div_ge};

  // face datapath
  always_ff @(posedge clk_i) begin
    // vertex capture
    if (s_fire) begin
      if (corner_q == 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          hp0_q[i] <= in_pos[i];
          hn0_q[i] <= in_nrm[i];
        end
      end else if (corner_q == 2'd1) begin
        for (int i = 0; i < 3; i++) begin
          hp1_q[i] <= in_pos[i];
          hn1_q[i] <= in_nrm[i];
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          fpos_q[0][i] <= hp0_q[i];
          fpos_q[1][i] <= hp1_q[i];
          fpos_q[2][i] <= in_pos[i];
          e1_q[i]   <= 17'(hp1_q[i]) - 17'(hp0_q[i]);
          e2_q[i]   <= 17'(in_pos[i]) - 17'(hp0_q[i]);
          nsum_q[i] <= 18'(hn0_q[i]) + 18'(hn1_q[i]) + 18'(in_nrm[i]);
          fn_q[i]   <= '0;
        end
        degen_q <= 1'b0;
      end
    end

    // multiplier results
    if ((state_q == ffn_pkg::ST_MUL_WAIT) && mac_res.done) begin
      if (op_q == ffn_pkg::OP_CX_B) c_q[0] <= mac_res.acc[34:0];
      if (op_q == ffn_pkg::OP_CY_B) c_q[1] <= mac_res.acc[34:0];
      if (op_q == ffn_pkg::OP_CZ_B) c_q[2] <= mac_res.acc[34:0];
      if (op_q == ffn_pkg::OP_DOT_Z) begin
        dot_neg_q <= mac_res.acc[ffn_pkg::ACC_W-1];
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= c_q[i][34] ? 34'(-c_q[i]) : 34'(c_q[i]);
        end
      end
      if (op_q == ffn_pkg::OP_SQ_Z) begin
        sq_v_q    <= mac_res.acc;
        sq_res_q  <= '0;
        sq_bit_q  <= 64'd1 << 62;
        sq_iter_q <= '0;
      end
    end

    // magnitude scaling, one bit per cycle
    if (state_q == ffn_pkg::ST_SCALE) begin
      if (all_zero) begin
        degen_q <= 1'b1;
      end else if (any_high) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= {1'b0, mag_q[i][33:1]};
      end else if (all_low) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= {mag_q[i][32:0], 1'b0};
      end
    end

    // square root, one result bit per cycle
    if (state_q == ffn_pkg::ST_SQRT) begin
      if (sq_v_q >= sq_t) begin
        sq_v_q   <= sq_v_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q  <= sq_bit_q >> 2;
      sq_iter_q <= sq_iter_q + 5'd1;
      if (sq_iter_q == ffn_pkg::SQRT_LAST) begin
        comp_q <= '0;
        dcnt_q <= '0;
      end
    end

    // restoring divide: a load step per component, then one quotient bit per cycle
    if (state_q == ffn_pkg::ST_DIV) begin
      if (dcnt_q == 4'd0) begin
        rem_q  <= {mag_q[comp_q][29:0], 14'd0} + 46'(r_w[30:1]);
        dvs_q  <= {1'b0, r_w, 14'd0};
        quo_q  <= '0;
        dcnt_q <= dcnt_q + 4'd1;
      end else begin
        if (div_ge) rem_q <= rem_q - dvs_q;
        dvs_q <= dvs_q >> 1;
        quo_q <= quo_fin;
        if (dcnt_q == ffn_pkg::DIV_LAST) begin
          fn_q[comp_q] <= (c_q[comp_q][34] ^ dot_neg_q) ?
                          -$signed({1'b0, quo_fin}) : $signed({1'b0, quo_fin});
          comp_q <= comp_q + 2'd1;
          dcnt_q <= '0;
        end else begin
          dcnt_q <= dcnt_q + 4'd1;
        end
      end
    end

    // output buffer payload
    if (buf_load) begin
      ebuf_pos_q <= fpos_q;
      ebuf_nrm_q <= fn_q;
      ebuf_deg_q <= degen_q;
    end
  end

  // output buffer control and vertex number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eleft_q <= '0;
      eidx_q  <= '0;
      vcnt_q  <= '0;
    end else begin
      if (buf_load) begin
        eleft_q <= 2'd3;
        eidx_q  <= '0;
      end else if (m_fire) begin
        eleft_q <= eleft_q - 2'd1;
        eidx_q  <= eidx_q + 2'd1;
      end
      if (m_fire) begin
        vcnt_q <= (vcnt_q == ffn_pkg::VNUM_LAST) ? '0 : vcnt_q + 16'd1;
      end
    end
  end

  // master side
  assign m_axis_tvalid = (eleft_q != 2'd0);
  assign m_axis_tlast  = (eidx_q == 2'd2);
  assign m_axis_tuser  = ebuf_deg_q;
  assign m_axis_tdata  = {vcnt_q, ebuf_nrm_q[2], ebuf_nrm_q[1], ebuf_nrm_q[0],
                          ebuf_pos_q[eidx_q][2], ebuf_pos_q[eidx_q][1],
                          ebuf_pos_q[eidx_q][0]};

endmodule

>>> design/ffn_checker.sv
// ----------------------------------------------------------------------------
// ffn_checker
// Port-level checks of the flat face normal unit.
// ----------------------------------------------------------------------------
module ffn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");

  // degenerate face carries a zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[95:48] == 48'd0))
    else $error("degenerate item with nonzero normal");

  // normal components stay within unit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      !($signed(m_axis_tdata[63:48]) > 16384 || $signed(m_axis_tdata[63:48]) < -16384 ||
        $signed(m_axis_tdata[79:64]) > 16384 || $signed(m_axis_tdata[79:64]) < -16384 ||
        $signed(m_axis_tdata[95:80]) > 16384 || $signed(m_axis_tdata[95:80]) < -16384))
    else $error("normal component out of range");

  // vertex number steps by one within a face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tdata[111:96] == $past(m_axis_tdata[111:96]) + 16'd1)
    else $error("vertex number did not advance");

endmodule

bind flat_face_normal_unit ffn_checker u_ffn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flat face normal unit: vertex items go in as
// triangle lists, the face normal, orientation flip, degenerate flag and
// running vertex number of every output item are checked against a local
// fixed point model of the face computation or a directed row's values.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 400;
  localparam int unsigned RAND_FACES  = 52;

  typedef struct packed {
    logic signed [15:0] nz, ny, nx, pz, py, px;
  } vertex_t;

  typedef struct {
    logic signed [15:0] px, py, pz, fx, fy, fz;
    logic [15:0]        vnum;
    logic               last, degen;
  } shaded_t;

  typedef struct {
    logic signed [15:0] fx, fy, fz;
    logic               degen, flipped;
  } normal_t;

  typedef struct {
    vertex_t            v;
    bit                 typed;
    logic signed [15:0] ex, ey, ez;
    logic               edeg;
  } row_t;

  logic          clk_i;
  logic          rst_ni;
  logic [95:0]   s_axis_tdata;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [111:0]  m_axis_tdata;
  logic          m_axis_tlast;
  logic          m_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;

  // vertex in: px, py, pz, nx, ny, nz (lowest first)
  // vertex out: px, py, pz, fx, fy, fz, vertex_number (lowest first)
  flat_face_normal_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  shaded_t     shaded_q[$];
  row_t        rows[$];
  vertex_t     held_v0, held_v1;
  int unsigned corners_held;
  logic [15:0] next_vnum;
  int unsigned errors, faces_done, degen_faces, flipped_faces;
  int unsigned items_sent, idle_tx, idle_rx, quiet_cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // exact cross product, orientation test and unit normal in Q1.14
  function automatic normal_t face_normal(vertex_t v0, vertex_t v1, vertex_t v2);
    longint             e1[3], e2[3], c[3], ns[3], dot;
    longint unsigned    mg[3], m, l2, r, probe, rem, q;
    logic signed [15:0] fn[3];
    normal_t            res;
    e1[0] = longint'(v1.px) - longint'(v0.px);
    e1[1] = longint'(v1.py) - longint'(v0.py);
    e1[2] = longint'(v1.pz) - longint'(v0.pz);
    e2[0] = longint'(v2.px) - longint'(v0.px);
    e2[1] = longint'(v2.py) - longint'(v0.py);
    e2[2] = longint'(v2.pz) - longint'(v0.pz);
    ns[0] = longint'(v0.nx) + longint'(v1.nx) + longint'(v2.nx);
    ns[1] = longint'(v0.ny) + longint'(v1.ny) + longint'(v2.ny);
    ns[2] = longint'(v0.nz) + longint'(v1.nz) + longint'(v2.nz);
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    dot = c[0] * ns[0] + c[1] * ns[1] + c[2] * ns[2];
    res.degen = (c[0] == 0) && (c[1] == 0) && (c[2] == 0);
    res.flipped = !res.degen && (dot < 0);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (mg[i] > m) m = mg[i];
      fn[i] = '0;
    end
    if (!res.degen) begin
      // bring the largest magnitude into [2^29, 2^30)
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
      end
      l2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
      // integer square root, two bits per step
      r = 0;
      rem = l2;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
        if (rem >= r + probe) begin
          rem = rem - (r + probe);
          r = (r >> 1) + probe;
        end else begin
          r = r >> 1;
        end
        probe = probe >> 2;
      end
      for (int i = 0; i < 3; i++) begin
        q = (mg[i] * 16384 + (r >> 1)) / r;
        fn[i] = (c[i] < 0) ? -16'(q) : 16'(q);
        if (dot < 0) fn[i] = -fn[i];
      end
    end
    res.fx = fn[0];
    res.fy = fn[1];
    res.fz = fn[2];
    return res;
  endfunction

  // track the open face and queue three shaded items on its third vertex
  task automatic take_vertex(row_t row);
    normal_t nrm;
    vertex_t vs[3];
    shaded_t s;
    if (corners_held == 0) begin
      held_v0 = row.v;
      corners_held = 1;
    end else if (corners_held == 1) begin
      held_v1 = row.v;
      corners_held = 2;
    end else begin
      nrm = face_normal(held_v0, held_v1, row.v);
      if (row.typed) begin
        nrm.fx = row.ex;
        nrm.fy = row.ey;
        nrm.fz = row.ez;
        nrm.degen = row.edeg;
      end
      vs[0] = held_v0;
      vs[1] = held_v1;
      vs[2] = row.v;
      for (int k = 0; k < 3; k++) begin
        s.px = vs[k].px;
        s.py = vs[k].py;
        s.pz = vs[k].pz;
        s.fx = nrm.fx;
        s.fy = nrm.fy;
        s.fz = nrm.fz;
        s.vnum = next_vnum;
        s.last = (k == 2);
        s.degen = nrm.degen;
        shaded_q = {shaded_q, s};
        next_vnum = (32'(next_vnum) + 1 >= ffn_pkg::MAX_VERTICES) ? '0 : next_vnum + 1'b1;
      end
      corners_held = 0;
      faces_done++;
      if (nrm.degen) degen_faces++;
      if (nrm.flipped) flipped_faces++;
    end
  endtask

  // drive one vertex item, with random idle cycles ahead of it
  task automatic send_vertex(row_t row);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_tx) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {row.v.nz, row.v.ny, row.v.nx, row.v.pz, row.v.py, row.v.px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    take_vertex(row);
    items_sent++;
    // idle pattern by phase of the run
    if (items_sent == 60) begin
      idle_tx = 63;
      idle_rx = 31;
    end else if (items_sent == 120) begin
      idle_tx = 0;
      idle_rx = 0;
    end
  endtask

  task automatic add_row(int px, int py, int pz, int nx, int ny, int nz,
                         bit typed = 0, int ex = 0, int ey = 0, int ez = 0,
                         bit edeg = 0);
    row_t r;
    r.v = {16'(nz), 16'(ny), 16'(nx), 16'(pz), 16'(py), 16'(px)};
    r.typed = typed;
    r.ex = 16'(ex);
    r.ey = 16'(ey);
    r.ez = 16'(ez);
    r.edeg = edeg;
    rows = {rows, r};
  endtask

  function automatic logic signed [15:0] rand_coord(bit near);
    return near ? 16'($urandom_range(128) - 64) : 16'($urandom);
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= idle_rx);
  end

  // output check and watchdog
  always @(posedge clk_i) begin
    shaded_t e;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (shaded_q.size() == 0) begin
          $display("%0t: unexpected item data=%h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          e = shaded_q.pop_front();
          if ({e.vnum, e.fz, e.fy, e.fx, e.pz, e.py, e.px} !== m_axis_tdata ||
              e.last !== m_axis_tlast || e.degen !== m_axis_tuser) begin
            $display("%0t: mismatch exp pos=%0d,%0d,%0d nrm=%0d,%0d,%0d vnum=%0d last=%0b deg=%0b",
                     $realtime, e.px, e.py, e.pz, e.fx, e.fy, e.fz, e.vnum, e.last, e.degen);
            $display("%0t:          act pos=%0d,%0d,%0d nrm=%0d,%0d,%0d vnum=%0d last=%0b deg=%0b",
                     $realtime, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                     $signed(m_axis_tdata[47:32]), $signed(m_axis_tdata[63:48]),
                     $signed(m_axis_tdata[79:64]), $signed(m_axis_tdata[95:80]),
                     m_axis_tdata[111:96], m_axis_tlast, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    row_t r;
    int   kind;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    corners_held  = 0;
    next_vnum     = '0;
    errors        = 0;
    faces_done    = 0;
    degen_faces   = 0;
    flipped_faces = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    idle_tx       = 31;
    idle_rx       = 63;

    // all-zero face: degenerate
    add_row(0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    // face in the xy plane, normals agree
    add_row(0, 0, 0, 0, 0, 16384);
    add_row(256, 0, 0, 0, 0, 16384);
    add_row(0, 256, 0, 0, 0, 16384, 1, 0, 0, 16384, 0);
    // same face, normals point away: flipped
    add_row(0, 0, 0, 0, 0, -16384);
    add_row(256, 0, 0, 0, 0, -16384);
    add_row(0, 256, 0, 0, 0, -16384, 1, 0, 0, -16384, 0);
    // zero normal sum: no flip
    add_row(0, 0, 0, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0);
    add_row(0, 256, 0, 0, 0, 0, 1, 0, 0, 16384, 0);
    // normal sum orthogonal to the face: zero dot, no flip
    add_row(0, 0, 0, 16384, 0, 0);
    add_row(256, 0, 0, 0, 0, 0);
    add_row(0, 256, 0, 0, 0, 0, 1, 0, 0, 16384, 0);
    // collinear corners: degenerate with nonzero edges
    add_row(1, 1, 1, 100, 200, 300);
    add_row(2, 2, 2, 100, 200, 300);
    add_row(3, 3, 3, 100, 200, 300, 1, 0, 0, 0, 1);
    // full-scale positions and extreme normals
    add_row(-32768, -32768, -32768, 32767, 32767, 32767);
    add_row(32767, -32768, -32768, -32768, -32768, -32768);
    add_row(-32768, 32767, -32768, 32767, -32768, 32767);
    // mixed extremes, tiny edge from first to third corner
    add_row(32767, 32767, 32767, -32768, 32767, -32768);
    add_row(-32768, 0, 32767, -1, -1, -1);
    add_row(32767, 32767, 32766, 1, 0, -1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_vertex(rows[i]);

    // random faces: mostly well formed, some degenerate, some tiny
    r.typed = 0;
    for (int f = 0; f < RAND_FACES; f++) begin
      kind = $urandom_range(9);
      for (int k = 0; k < 3; k++) begin
        r.v = {16'($urandom), 16'($urandom), 16'($urandom),
               rand_coord(kind >= 7), rand_coord(kind >= 7), rand_coord(kind >= 7)};
        // repeated corner makes a degenerate face
        if (kind == 0 && k == 2) begin
          r.v.px = held_v0.px;
          r.v.py = held_v0.py;
          r.v.pz = held_v0.pz;
        end
        send_vertex(r);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (shaded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d vertices, %0d faces (%0d degenerate, %0d flipped)",
             items_sent, faces_done, degen_faces, flipped_faces);
    $display("idle patterns: sender-heavy, receiver-heavy and none; %0d errors", errors);
    if (errors == 0 && shaded_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> flat_face_normal_unit.f
design/ffn_pkg.sv
design/ffn_mac.sv
design/flat_face_normal_unit.sv
design/ffn_checker.sv
verif/tb.sv
